/* rtl/core/bq_pkg.sv */
// ============================================================================
// bq_pkg
// Shared sizes, codes and types of the cascaded biquad filter.
// ============================================================================
`default_nettype none

package bq_pkg;

    localparam int SECTIONS    = 4;
    localparam int COEF_PER_SEC = 5;
    localparam int COEF_DEPTH  = SECTIONS * COEF_PER_SEC;
    localparam int DELAY_DEPTH = SECTIONS * 2;
    localparam int CADDR_W     = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int DADDR_W     = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int NS_W        = $clog2(SECTIONS + 1);

    localparam int SHIFT_W     = 4;
    localparam int SEC_CFG_W   = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int SAMPLE_W    = 16;
    localparam int CIDX_W      = 5;
    localparam int COEF_W      = 16;
    localparam int DELAY_W     = 32;
    localparam int ACC_W       = 64;
    localparam int OPND_W      = 33;
    localparam int PROD_W      = OPND_W + COEF_W;

    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECTIONS   = 2'd1;

    localparam logic [SHIFT_W-1:0]   SHIFT_RESET    = 4'd14;
    localparam logic [SEC_CFG_W-1:0] SECTIONS_RESET = 3'd1;

    localparam int CO_B0 = 0;
    localparam int CO_B1 = 1;
    localparam int CO_B2 = 2;
    localparam int CO_A1 = 3;
    localparam int CO_A2 = 4;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_ADD,
        OP_SUB,
        OP_ADD_HI
    } acc_op_t;

    typedef struct packed {
        logic    init;
        acc_op_t op;
    } mac_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/biquad_cascade_df2_fixed.sv */
// ============================================================================
// biquad_cascade_df2_fixed
// Cascade of direct form II biquad sections in fixed point. Coefficients and
// delays sit in two small RAMs; one shared multiply-accumulate unit does all
// products of a sample in turn.
// ============================================================================
//
//  channel  | signals                                     | moves
//  ---------+---------------------------------------------+-------------------
//  s_       | s_valid s_ready s_mode s_sample             | one input item
//           | s_coef_index s_coef_value                   |
//  m_       | m_valid m_ready m_filtered_out              | one filtered item
//  cfg_     | cfg_wr_en cfg_index cfg_wdata               | register write
//
//  A sample item raises m_valid once the n sections in use have run (the
//  section steps are skipped when no section is in use), and the next item
//  is accepted only once the block is back in idle; each section's steps
//  run in turn, as set by the single multiplier and the single read port
//  of each RAM. A coefficient item is written on acceptance and gives no
//  result. Reset is synchronous; the RAMs need no clearing pass, since
//  per-entry valid bits make unwritten entries read as zero. A result
//  waiting on m_ready does not block the next acceptance; the following
//  result then waits in its final step.
// ============================================================================
`default_nettype none

module biquad_cascade_df2_fixed (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_mode,
    input  wire logic signed [bq_pkg::SAMPLE_W-1:0]   s_sample,
    input  wire logic        [bq_pkg::CIDX_W-1:0]     s_coef_index,
    input  wire logic signed [bq_pkg::COEF_W-1:0]     s_coef_value,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed      [bq_pkg::DELAY_W-1:0]    m_filtered_out,
    input  wire logic                                 cfg_wr_en,
    input  wire logic        [bq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [bq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import bq_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RUN  = 5'b00010,
        ST_TAIL = 5'b00100,
        ST_WAIT = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    localparam logic [2:0] STP_RD_D1  = 3'd0;
    localparam logic [2:0] STP_MUL_A1 = 3'd1;
    localparam logic [2:0] STP_MUL_A2 = 3'd2;
    localparam logic [2:0] STP_WR_D2  = 3'd3;
    localparam logic [2:0] STP_ROUND  = 3'd4;
    localparam logic [2:0] STP_MUL_LO = 3'd5;
    localparam logic [2:0] STP_MUL_HI = 3'd6;
    localparam logic [2:0] STP_MUL_B1 = 3'd7;

    state_t                     state_reg;
    state_t                     state_next;
    logic [2:0]                 step_reg;
    logic                       tail_reg;
    logic [NS_W-1:0]            sec_left_reg;
    logic [CADDR_W-1:0]         cbase_reg;
    logic [DADDR_W-1:0]         dbase_reg;
    logic [DELAY_W-1:0]         d1_reg;
    logic [DELAY_W-1:0]         d2_reg;
    logic [ACC_W-1:0]           rnd_reg;
    logic [SHIFT_W-1:0]         shift_bits_reg;
    logic [SEC_CFG_W-1:0]       sec_cfg_reg;
    logic                       m_valid_reg;
    logic [DELAY_W-1:0]         m_data_reg;

    logic [COEF_DEPTH-1:0]      cvalid_reg;
    logic [DELAY_DEPTH-1:0]     dvalid_reg;
    logic                       cvld_q_reg;
    logic                       dvld_q_reg;

    logic                       accept;
    logic                       c_we;
    logic [CADDR_W-1:0]         c_ra;
    logic [COEF_W-1:0]          c_q;
    logic signed [COEF_W-1:0]   c_eff;
    logic                       d_we;
    logic [DADDR_W-1:0]         d_wa;
    logic [DELAY_W-1:0]         d_wd;
    logic [DADDR_W-1:0]         d_ra;
    logic [DELAY_W-1:0]         d_q;
    logic [DELAY_W-1:0]         d_eff;

    mac_cmd_t                   cmd;
    logic signed [OPND_W-1:0]   opnd;
    logic [ACC_W-1:0]           init_val;
    logic [ACC_W-1:0]           acc;
    logic [ACC_W-1:0]           offs;
    logic signed [ACC_W-1:0]    acc_sum;
    logic [ACC_W-1:0]           rnd_val;
    logic [NS_W-1:0]            n_sec;
    logic                       out_free;

    assign s_ready        = (state_reg == ST_IDLE);
    assign accept         = s_valid && s_ready;
    assign m_valid        = m_valid_reg;
    assign m_filtered_out = m_data_reg;
    assign out_free       = !m_valid_reg || m_ready;

    assign c_we  = accept && s_mode && (int'(s_coef_index) < COEF_DEPTH);
    assign c_eff = cvld_q_reg ? c_q : '0;
    assign d_eff = dvld_q_reg ? d_q : '0;

    assign init_val = {{(ACC_W - SAMPLE_W){s_sample[SAMPLE_W-1]}}, s_sample} << shift_bits_reg;

    always_comb begin
        if (int'(sec_cfg_reg) > SECTIONS) begin
            n_sec = NS_W'(SECTIONS);
        end else begin
            n_sec = NS_W'(sec_cfg_reg);
        end
    end

    always_comb begin
        if (shift_bits_reg == '0) begin
            offs = '0;
        end else begin
            offs = 64'd1 << (shift_bits_reg - SHIFT_W'(1));
        end
        acc_sum = acc + offs;
        rnd_val = acc_sum >>> shift_bits_reg;
    end

    bq_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
        .aclk  (aclk),
        .we    (c_we),
        .waddr (CADDR_W'(s_coef_index)),
        .wdata (s_coef_value),
        .raddr (c_ra),
        .rdata (c_q)
    );

    bq_ram #(.WIDTH(DELAY_W), .DEPTH(DELAY_DEPTH)) u_delay_ram (
        .aclk  (aclk),
        .we    (d_we),
        .waddr (d_wa),
        .wdata (d_wd),
        .raddr (d_ra),
        .rdata (d_q)
    );

    bq_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .opnd     (opnd),
        .coef     (c_eff),
        .init_val (init_val),
        .acc      (acc)
    );

    // per-section schedule and MAC issue
    always_comb begin
        cmd.init = accept && !s_mode;
        cmd.op   = OP_NONE;
        opnd     = {d2_reg[DELAY_W-1], d2_reg};
        c_ra     = cbase_reg + CADDR_W'(CO_A1);
        d_ra     = dbase_reg;
        d_we     = 1'b0;
        d_wa     = dbase_reg;
        d_wd     = rnd_reg[DELAY_W-1:0];
        case (state_reg)
            ST_RUN: begin
                case (step_reg)
                    STP_RD_D1: begin
                        if (tail_reg) begin
                            cmd.op = OP_ADD;
                        end
                    end
                    STP_MUL_A1: begin
                        opnd   = {d_eff[DELAY_W-1], d_eff};
                        cmd.op = OP_SUB;
                        d_ra   = dbase_reg + DADDR_W'(1);
                        c_ra   = cbase_reg + CADDR_W'(CO_A2);
                    end
                    STP_MUL_A2: begin
                        opnd   = {d_eff[DELAY_W-1], d_eff};
                        cmd.op = OP_SUB;
                    end
                    STP_WR_D2: begin
                        d_we = 1'b1;
                        d_wa = dbase_reg + DADDR_W'(1);
                        d_wd = d1_reg;
                    end
                    STP_ROUND: begin
                        c_ra = cbase_reg + CADDR_W'(CO_B0);
                    end
                    STP_MUL_LO: begin
                        opnd   = {1'b0, rnd_reg[31:0]};
                        cmd.op = OP_LOAD;
                        c_ra   = cbase_reg + CADDR_W'(CO_B0);
                        d_we   = 1'b1;
                    end
                    STP_MUL_HI: begin
                        opnd   = {rnd_reg[63], rnd_reg[63:32]};
                        cmd.op = OP_ADD_HI;
                        c_ra   = cbase_reg + CADDR_W'(CO_B1);
                    end
                    STP_MUL_B1: begin
                        opnd   = {d1_reg[DELAY_W-1], d1_reg};
                        cmd.op = OP_ADD;
                        c_ra   = cbase_reg + CADDR_W'(CO_B2);
                    end
                    default: begin
                        cmd.op = OP_NONE;
                    end
                endcase
            end
            ST_TAIL: begin
                cmd.op = OP_ADD;
            end
            default: begin
                cmd.op = OP_NONE;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && !s_mode) begin
                    state_next = (n_sec == '0) ? ST_FIN : ST_RUN;
                end
            end
            ST_RUN: begin
                if (step_reg == STP_MUL_B1 && sec_left_reg == NS_W'(1)) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: state_next = ST_WAIT;
            ST_WAIT: state_next = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= STP_RD_D1;
            tail_reg     <= 1'b0;
            sec_left_reg <= '0;
            cbase_reg    <= '0;
            dbase_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (accept && !s_mode) begin
                step_reg     <= STP_RD_D1;
                tail_reg     <= 1'b0;
                sec_left_reg <= n_sec;
                cbase_reg    <= '0;
                dbase_reg    <= '0;
            end else if (state_reg == ST_RUN) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == STP_RD_D1) begin
                    tail_reg <= 1'b0;
                end
                if (step_reg == STP_MUL_B1) begin
                    tail_reg     <= 1'b1;
                    sec_left_reg <= sec_left_reg - NS_W'(1);
                    cbase_reg    <= cbase_reg + CADDR_W'(COEF_PER_SEC);
                    dbase_reg    <= dbase_reg + DADDR_W'(2);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RUN && step_reg == STP_MUL_A1) begin
            d1_reg <= d_eff;
        end
        if (state_reg == ST_RUN && step_reg == STP_MUL_A2) begin
            d2_reg <= d_eff;
        end
        if (state_reg == ST_RUN && step_reg == STP_ROUND) begin
            rnd_reg <= rnd_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cvalid_reg <= '0;
            dvalid_reg <= '0;
            cvld_q_reg <= 1'b0;
            dvld_q_reg <= 1'b0;
        end else begin
            if (c_we) begin
                cvalid_reg[CADDR_W'(s_coef_index)] <= 1'b1;
            end
            if (d_we) begin
                dvalid_reg[d_wa] <= 1'b1;
            end
            cvld_q_reg <= cvalid_reg[c_ra];
            dvld_q_reg <= dvalid_reg[d_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_bits_reg <= SHIFT_RESET;
            sec_cfg_reg    <= SECTIONS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SHIFT_BITS: shift_bits_reg <= cfg_wdata[SHIFT_W-1:0];
                REG_SECTIONS:   sec_cfg_reg    <= cfg_wdata[SEC_CFG_W-1:0];
                default:        sec_cfg_reg    <= sec_cfg_reg;
            endcase
        end
    end

    // hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_FIN && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && out_free) begin
            m_data_reg <= rnd_val[DELAY_W-1:0];
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (sec_left_reg != '0 && int'(sec_left_reg) <= SECTIONS))
        else $error("section count out of range while running");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && step_reg == STP_MUL_B1)
            |=> (cbase_reg == $past(cbase_reg) + CADDR_W'(COEF_PER_SEC)))
        else $error("coefficient base did not advance by one section");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside the final step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        d_we |-> (int'(d_wa) < DELAY_DEPTH && state_reg == ST_RUN))
        else $error("delay write outside the running sections");

endmodule

`default_nettype wire

/* rtl/core/bq_ram.sv */
// ============================================================================
// bq_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module bq_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 20,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/bq_mac.sv */
// ============================================================================
// bq_mac
// Shared multiply-accumulate unit: registered 33x16 product, 64-bit
// wrapping accumulator.
// ============================================================================
`default_nettype none

module bq_mac (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire bq_pkg::mac_cmd_t                   cmd,
    input  wire logic signed [bq_pkg::OPND_W-1:0]   opnd,
    input  wire logic signed [bq_pkg::COEF_W-1:0]   coef,
    input  wire logic        [bq_pkg::ACC_W-1:0]    init_val,
    output logic             [bq_pkg::ACC_W-1:0]    acc
);
    import bq_pkg::*;

    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    acc_op_t                  op_reg;
    logic        [ACC_W-1:0]  prod_ext;
    logic        [ACC_W-1:0]  acc_reg;

    assign prod_next = opnd * coef;
    assign prod_ext  = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc       = acc_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (!aresetn) begin
            op_reg <= OP_NONE;
        end else begin
            op_reg <= cmd.op;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            acc_reg <= init_val;
        end else begin
            case (op_reg)
                OP_LOAD:   acc_reg <= prod_ext;
                OP_ADD:    acc_reg <= acc_reg + prod_ext;
                OP_SUB:    acc_reg <= acc_reg - prod_ext;
                OP_ADD_HI: acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
                default:   acc_reg <= acc_reg;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.init |-> (op_reg == OP_NONE))
        else $error("accumulator init collides with a pending product");

endmodule

`default_nettype wire
